// ===== hw/rtl/prtt_pkg.sv =====
`default_nettype none

package prtt_pkg;

  // command codes
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;

  localparam logic [2:0] STATIC_COUNT_RESET = 3'd2;

  // one stored slot, without its valid mark
  typedef struct packed {
    logic [15:0] task_id;
    logic [63:0] runtime;
    logic [63:0] last_resume;
  } entry_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } alu_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prtt_alu.sv =====
`default_nettype none

// shared 64-bit add / subtract
module prtt_alu (
  input  var prtt_pkg::alu_op_t op,
  input  wire logic [63:0]      a,
  input  wire logic [63:0]      b,
  output logic      [63:0]      y
);

  logic [63:0] b_eff;

  always_comb begin
    b_eff = (op == prtt_pkg::OP_SUB) ? ~b : b;
    y     = a + b_eff + {63'd0, (op == prtt_pkg::OP_SUB)};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/per_task_runtime_table_unit.sv =====
`default_nettype none

// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+------------------------------
// command   | command, task_id, timestamp, slot_select          | taken when start && !busy
// result    | status, slot_index, slot_valid, slot_task_id,     | one-cycle word marked by done
//           | slot_runtime, slot_start_time, live_tasks         |
// config    | cfg_write, static_task_count                      | written when cfg_write
//
// init fills slots 0 to k-1 (k = static task count); read answers from the
// registered memory read port. start, stop, suspend and resume walk the slot
// table one slot a cycle through the same port, and suspend then makes its two
// passes through the shared adder.
// commands answered at once (before init, unknown code, bad slot) skip the walk.
// rst is synchronous; it clears the valid marks, the live count and the init
// flag at once, so there is no clearing pass. the receiver cannot stall: each
// result word shows for exactly one cycle.
module per_task_runtime_table_unit #(
  parameter int MAX_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  command,
  input  wire logic [15:0] task_id,
  input  wire logic [63:0] timestamp,
  input  wire logic [4:0]  slot_select,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  static_task_count,
  output logic             busy,
  output logic             done,
  output logic      [1:0]  status,
  output logic      [4:0]  slot_index,
  output logic             slot_valid,
  output logic      [15:0] slot_task_id,
  output logic      [63:0] slot_runtime,
  output logic      [63:0] slot_start_time,
  output logic      [5:0]  live_tasks
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int TW = $clog2(MAX_SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(MAX_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_SUB,
    S_ADD,
    S_READ
  } state_t;

  state_t               state;
  logic [2:0]           cmd_q;
  logic [15:0]          id_q;
  logic [63:0]          ts_q;
  logic [IW-1:0]        sel_q;
  logic [IW-1:0]        addr_q;
  logic                 cmp_vld;
  logic                 valid_q;
  prtt_pkg::entry_t     entry;
  logic [63:0]          acc;
  logic [TW-1:0]        init_cnt;
  logic [MAX_SLOTS-1:0] valid;
  logic [TW-1:0]        total;
  logic                 initialized;
  logic [2:0]           static_count;

  // slot table storage
  prtt_pkg::entry_t mem [MAX_SLOTS];
  prtt_pkg::entry_t rd_data;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  prtt_pkg::entry_t mem_wd;

  logic [TW-1:0]     k_eff;
  logic [IW-1:0]     scan_first;
  logic              hit;
  prtt_pkg::alu_op_t alu_op;
  logic [63:0]       alu_a;
  logic [63:0]       alu_b;
  logic [63:0]       alu_y;
  logic              sel_ok;

  assign busy   = (state != S_IDLE);
  assign k_eff  = (int'(static_count) > MAX_SLOTS) ? TW'(MAX_SLOTS) : TW'(static_count);
  assign sel_ok = (int'(slot_select) < MAX_SLOTS);

  // suspend and resume search from slot 0, start and stop from slot 1
  assign scan_first = ((cmd_q == prtt_pkg::CMD_SUSPEND) || (cmd_q == prtt_pkg::CMD_RESUME))
                      ? '0 : IW'(1);

  // compare stage of the walk: start wants a free slot, the rest a live id
  assign hit = cmp_vld && ((cmd_q == prtt_pkg::CMD_START) ? !valid_q
                           : (valid_q && (rd_data.task_id == id_q)));

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = IW'(slot_select);
      S_SCAN:  rd_addr = cmp_vld ? (addr_q + IW'(1)) : scan_first;
      default: rd_addr = addr_q;
    endcase
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = '0;
    unique case (state)
      S_INIT: begin
        mem_we = (init_cnt != k_eff);
        mem_wa = init_cnt[IW-1:0];
        mem_wd.task_id = 16'(init_cnt);
      end
      S_SCAN: begin
        if (hit) begin
          case (cmd_q)
            prtt_pkg::CMD_START: begin
              mem_we = 1'b1;
              mem_wd.task_id = id_q;
            end
            prtt_pkg::CMD_STOP: begin
              mem_we = 1'b1;
            end
            prtt_pkg::CMD_RESUME: begin
              mem_we = 1'b1;
              mem_wd.task_id     = rd_data.task_id;
              mem_wd.runtime     = rd_data.runtime;
              mem_wd.last_resume = ts_q;
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      S_ADD: begin
        mem_we = 1'b1;
        mem_wd.task_id     = entry.task_id;
        mem_wd.runtime     = alu_y;
        mem_wd.last_resume = entry.last_resume;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // suspend: first pass forms the elapsed time, second pass accumulates it
  always_comb begin
    if (state == S_SUB) begin
      alu_op = prtt_pkg::OP_SUB;
      alu_a  = ts_q;
      alu_b  = entry.last_resume;
    end else begin
      alu_op = prtt_pkg::OP_ADD;
      alu_a  = entry.runtime;
      alu_b  = acc;
    end
  end

  prtt_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      cmp_vld      <= 1'b0;
      valid        <= '0;
      total        <= '0;
      initialized  <= 1'b0;
      static_count <= prtt_pkg::STATIC_COUNT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        static_count <= static_task_count;
      end

      // default result word: no slot touched
      if (state == S_IDLE || state == S_INIT || state == S_SCAN) begin
        slot_index      <= '0;
        slot_valid      <= 1'b0;
        slot_task_id    <= '0;
        slot_runtime    <= '0;
        slot_start_time <= '0;
        live_tasks      <= 6'(total);
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= command;
            id_q    <= task_id;
            ts_q    <= timestamp;
            cmp_vld <= 1'b0;
            if (command == prtt_pkg::CMD_INIT) begin
              valid    <= '0;
              init_cnt <= '0;
              state    <= S_INIT;
            end else if (command > prtt_pkg::CMD_READ) begin
              done   <= 1'b1;
              status <= prtt_pkg::ST_FAIL;
            end else if (!initialized) begin
              done   <= 1'b1;
              status <= prtt_pkg::ST_IGNORED;
            end else if (command == prtt_pkg::CMD_READ) begin
              if (sel_ok) begin
                sel_q <= IW'(slot_select);
                state <= S_READ;
              end else begin
                done       <= 1'b1;
                status     <= prtt_pkg::ST_FAIL;
                slot_index <= slot_select;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_INIT: begin
          if (init_cnt == k_eff) begin
            total       <= k_eff;
            initialized <= 1'b1;
            done        <= 1'b1;
            status      <= prtt_pkg::ST_DONE;
            live_tasks  <= 6'(k_eff);
            state       <= S_IDLE;
          end else begin
            valid[init_cnt[IW-1:0]] <= 1'b1;
            init_cnt                <= init_cnt + TW'(1);
          end
        end

        S_SCAN: begin
          if (hit) begin
            slot_index <= 5'(addr_q);
            state      <= S_IDLE;
            case (cmd_q)
              prtt_pkg::CMD_START: begin
                valid[addr_q] <= 1'b1;
                total         <= total + TW'(1);
                done          <= 1'b1;
                status        <= prtt_pkg::ST_DONE;
                slot_valid    <= 1'b1;
                slot_task_id  <= id_q;
                live_tasks    <= 6'(total + TW'(1));
              end
              prtt_pkg::CMD_STOP: begin
                valid[addr_q] <= 1'b0;
                total         <= total - TW'(1);
                done          <= 1'b1;
                status        <= prtt_pkg::ST_DONE;
                live_tasks    <= 6'(total - TW'(1));
              end
              prtt_pkg::CMD_RESUME: begin
                done            <= 1'b1;
                status          <= prtt_pkg::ST_DONE;
                slot_valid      <= 1'b1;
                slot_task_id    <= rd_data.task_id;
                slot_runtime    <= rd_data.runtime;
                slot_start_time <= ts_q;
              end
              default: begin
                // suspend needs two adder passes
                entry <= rd_data;
                state <= S_SUB;
              end
            endcase
          end else if (cmp_vld && (addr_q == LAST)) begin
            done   <= 1'b1;
            status <= prtt_pkg::ST_FAIL;
            state  <= S_IDLE;
          end else begin
            addr_q  <= rd_addr;
            valid_q <= valid[rd_addr];
            cmp_vld <= 1'b1;
          end
        end

        S_SUB: begin
          acc   <= alu_y;
          state <= S_ADD;
        end

        S_ADD: begin
          done            <= 1'b1;
          status          <= prtt_pkg::ST_DONE;
          slot_index      <= 5'(addr_q);
          slot_valid      <= 1'b1;
          slot_task_id    <= entry.task_id;
          slot_runtime    <= alu_y;
          slot_start_time <= entry.last_resume;
          live_tasks      <= 6'(total);
          state           <= S_IDLE;
        end

        S_READ: begin
          done            <= 1'b1;
          status          <= prtt_pkg::ST_DONE;
          slot_index      <= 5'(sel_q);
          slot_valid      <= valid[sel_q];
          slot_task_id    <= rd_data.task_id;
          slot_runtime    <= rd_data.runtime;
          slot_start_time <= rd_data.last_resume;
          live_tasks      <= 6'(total);
          state           <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prtt_checker.sv =====
`default_nettype none

module prtt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic        slot_valid,
  input wire logic [15:0] slot_task_id,
  input wire logic [63:0] slot_runtime,
  input wire logic [63:0] slot_start_time,
  input wire logic [5:0]  live_tasks
);

  // a word only follows an accepted command or a busy cycle
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result word without a pending command");

  // every accepted command either answers at once or goes busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither answered nor busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == prtt_pkg::ST_DONE) || (status == prtt_pkg::ST_IGNORED)
              || (status == prtt_pkg::ST_FAIL)))
    else $error("undefined status code");

  // failed or ignored commands carry no slot contents
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status != prtt_pkg::ST_DONE)) |->
      (!slot_valid && (slot_task_id == 16'd0) && (slot_runtime == 64'd0)
       && (slot_start_time == 64'd0)))
    else $error("slot contents on a failed command");

  // before init the table holds no tasks
  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == prtt_pkg::ST_IGNORED)) |-> (live_tasks == 6'd0))
    else $error("live tasks before init");

endmodule

bind per_task_runtime_table_unit prtt_checker u_prtt_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .slot_valid      (slot_valid),
  .slot_task_id    (slot_task_id),
  .slot_runtime    (slot_runtime),
  .slot_start_time (slot_start_time),
  .live_tasks      (live_tasks)
);

`default_nettype wire
